FILE: hdl/psfs_pkg.sv
// Shared constants, codes and control structures of the sound-effect sequencer.
package psfs_pkg;

    localparam int TRACKS_DEF   = 4;
    localparam int SOUNDS_DEF   = 32;
    localparam int STEPS_DEF    = 256;
    localparam int CHANNELS_DEF = 2;

    localparam int ACTION_W   = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;
    localparam int STEP_W     = 23;
    localparam int SOUND_W    = 16;

    localparam logic [ACTION_W-1:0] ACT_LOAD_STEP  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_SOUND = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD        = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_KILL       = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_KILL_REP   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd5;

    localparam logic [1:0] KIND_STOP = 2'd1;
    localparam logic [1:0] KIND_LOOP = 2'd2;

    typedef struct packed {
        logic cap_item;
        logic wr_step;
        logic wr_sound;
        logic kill;
        logic kill_rep;
        logic sound_rd;
        logic add_cap;
        logic scan_rst;
        logic scan_inc;
        logic add_eval;
        logic add_rd_step;
        logic add_commit;
        logic clr_claim;
        logic tick_chk;
        logic tick_kind;
        logic tick_loop_fin;
        logic ch_start;
        logic ch_zero;
        logic ch_rd;
        logic ch_ev;
        logic ch_out;
        logic ch_next;
    } psfs_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                cur_busy;
        logic                cur_claimed;
        logic                delay_zero;
        logic                kind_loop;
        logic                last_track;
        logic                add_go;
        logic                last_chan;
        logic                out_taken;
    } psfs_stat_t;

endpackage

FILE: hdl/psfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/psfs_ctrl.sv
// Controller state machine that sequences loads, adds, kills and ticks.
module psfs_ctrl
    import psfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  psfs_stat_t stat,
    output logic       in_ready,
    output psfs_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DISP   = 14'b00000000000010,
        S_A_CAP  = 14'b00000000000100,
        S_A_SCAN = 14'b00000000001000,
        S_A_DEC  = 14'b00000000010000,
        S_A_STEP = 14'b00000000100000,
        S_A_FIN  = 14'b00000001000000,
        S_T_CHK  = 14'b00000010000000,
        S_T_KIND = 14'b00000100000000,
        S_T_LOOP = 14'b00001000000000,
        S_C_SCAN = 14'b00010000000000,
        S_C_EV   = 14'b00100000000000,
        S_C_OUT  = 14'b01000000000000,
        S_C_WAIT = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.cap_item = in_fire;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.action)
                    ACT_LOAD_STEP:
                    begin
                        cmd.wr_step = 1'b1;
                        state_next  = S_IDLE;
                    end
                    ACT_LOAD_SOUND:
                    begin
                        cmd.wr_sound = 1'b1;
                        state_next   = S_IDLE;
                    end
                    ACT_ADD:
                    begin
                        cmd.sound_rd = 1'b1;
                        state_next   = S_A_CAP;
                    end
                    ACT_KILL:
                    begin
                        cmd.kill   = 1'b1;
                        state_next = S_IDLE;
                    end
                    ACT_KILL_REP:
                    begin
                        cmd.kill_rep = 1'b1;
                        state_next   = S_IDLE;
                    end
                    ACT_TICK:
                    begin
                        cmd.clr_claim = 1'b1;
                        cmd.scan_rst  = 1'b1;
                        state_next    = S_T_CHK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_A_CAP:
            begin
                cmd.add_cap  = 1'b1;
                cmd.scan_rst = 1'b1;
                state_next   = S_A_SCAN;
            end
            S_A_SCAN:
            begin
                cmd.add_eval = 1'b1;
                if (!stat.cur_busy)
                begin
                    state_next = S_A_STEP;
                end
                else if (stat.last_track)
                begin
                    state_next = S_A_DEC;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_A_DEC:
            begin
                state_next = stat.add_go ? S_A_STEP : S_IDLE;
            end
            S_A_STEP:
            begin
                cmd.add_rd_step = 1'b1;
                state_next      = S_A_FIN;
            end
            S_A_FIN:
            begin
                cmd.add_commit = 1'b1;
                state_next     = S_IDLE;
            end
            S_T_CHK, S_T_KIND, S_T_LOOP:
            begin
                cmd.tick_chk      = (state_reg == S_T_CHK);
                cmd.tick_kind     = (state_reg == S_T_KIND);
                cmd.tick_loop_fin = (state_reg == S_T_LOOP);
                if (state_reg == S_T_CHK && stat.cur_busy && stat.delay_zero)
                begin
                    state_next = S_T_KIND;
                end
                else if (state_reg == S_T_KIND && stat.kind_loop)
                begin
                    state_next = S_T_LOOP;
                end
                else if (stat.last_track)
                begin
                    cmd.ch_start = 1'b1;
                    cmd.ch_zero  = 1'b1;
                    state_next   = S_C_SCAN;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_T_CHK;
                end
            end
            S_C_SCAN:
            begin
                if (stat.cur_busy && !stat.cur_claimed)
                begin
                    cmd.ch_rd  = 1'b1;
                    state_next = S_C_EV;
                end
                else if (stat.last_track)
                begin
                    state_next = S_C_OUT;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_C_EV:
            begin
                cmd.ch_ev = 1'b1;
                if (stat.last_track)
                begin
                    state_next = S_C_OUT;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_C_SCAN;
                end
            end
            S_C_OUT:
            begin
                cmd.ch_out = 1'b1;
                state_next = S_C_WAIT;
            end
            S_C_WAIT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.last_chan)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.ch_next  = 1'b1;
                        cmd.ch_start = 1'b1;
                        state_next   = S_C_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/psfs_dp.sv
// Datapath: item register, step and sound memories, track registers, output register.
module psfs_dp
    import psfs_pkg::*;
#(
    parameter int TRACKS   = TRACKS_DEF,
    parameter int SOUNDS   = SOUNDS_DEF,
    parameter int STEPS    = STEPS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ACTION_W-1:0]   in_user,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  psfs_cmd_t             cmd,
    output psfs_stat_t            stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    localparam int TW  = $clog2(TRACKS);
    localparam int SW  = $clog2(SOUNDS);
    localparam int PW  = $clog2(STEPS);
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Captured input item.
    logic [ACTION_W-1:0] act_reg;
    logic [4:0]          id_reg;
    logic [7:0]          addr_reg;
    logic [1:0]          kind_reg;
    logic [3:0]          ctrl_reg;
    logic [4:0]          freq_reg;
    logic [3:0]          vol_reg;
    logic [7:0]          ticks_reg;
    logic [7:0]          prio_reg;

    // Track state; rank and start mirror the sound table for each track's sound.
    logic              busy_reg  [TRACKS];
    logic              clm_reg   [TRACKS];
    logic [SW-1:0]     snd_reg   [TRACKS];
    logic [PW-1:0]     ptr_reg   [TRACKS];
    logic [7:0]        dly_reg   [TRACKS];
    logic signed [7:0] rank_reg  [TRACKS];
    logic [PW-1:0]     start_reg [TRACKS];

    logic [TW-1:0]     ti_reg;
    logic [TW-1:0]     pick_reg;
    logic              pv_reg;
    logic signed [7:0] prank_reg;
    logic [PW-1:0]     nstart_reg;
    logic signed [7:0] nrank_reg;

    logic [CHW-1:0]    ch_reg;
    logic              bv_reg;
    logic [TW-1:0]     best_reg;
    logic [3:0]        bvol_reg;
    logic [3:0]        bctrl_reg;
    logic [4:0]        bfreq_reg;
    logic signed [7:0] brank_reg;

    logic       ov_reg;
    logic       o_chan_reg;
    logic [3:0] o_ctrl_reg;
    logic [4:0] o_freq_reg;
    logic [3:0] o_vol_reg;
    logic       o_last_reg;

    logic [SW-1:0]      id_idx;
    logic [PW-1:0]      step_raddr;
    logic               step_re;
    logic [STEP_W-1:0]  srd;
    logic [SOUND_W-1:0] snd_rd;
    logic [1:0]         srd_kind;
    logic [3:0]         srd_ctrl;
    logic [4:0]         srd_freq;
    logic [3:0]         srd_vol;
    logic [7:0]         srd_ticks;

    assign id_idx    = SW'(id_reg);
    assign srd_kind  = srd[22:21];
    assign srd_ctrl  = srd[20:17];
    assign srd_freq  = srd[16:12];
    assign srd_vol   = srd[11:8];
    assign srd_ticks = srd[7:0];

    always_comb
    begin
        step_re = cmd.tick_chk | cmd.tick_kind | cmd.add_rd_step | cmd.ch_rd;
        priority if (cmd.tick_chk)
        begin
            step_raddr = ptr_reg[ti_reg] + PW'(1);
        end
        else if (cmd.tick_kind)
        begin
            step_raddr = start_reg[ti_reg];
        end
        else if (cmd.add_rd_step)
        begin
            step_raddr = nstart_reg;
        end
        else
        begin
            step_raddr = ptr_reg[ti_reg];
        end
    end

    psfs_ram #(.WIDTH(STEP_W), .DEPTH(STEPS)) u_step_ram (
        .clk   (clk),
        .we    (cmd.wr_step),
        .waddr (PW'(addr_reg)),
        .wdata ({kind_reg, ctrl_reg, freq_reg, vol_reg, ticks_reg}),
        .re    (step_re),
        .raddr (step_raddr),
        .rdata (srd)
    );

    psfs_ram #(.WIDTH(SOUND_W), .DEPTH(SOUNDS)) u_sound_ram (
        .clk   (clk),
        .we    (cmd.wr_sound),
        .waddr (id_idx),
        .wdata ({addr_reg, prio_reg}),
        .re    (cmd.sound_rd),
        .raddr (id_idx),
        .rdata (snd_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_item)
        begin
            act_reg   <= in_user;
            id_reg    <= in_data[4:0];
            addr_reg  <= in_data[12:5];
            kind_reg  <= in_data[14:13];
            ctrl_reg  <= in_data[18:15];
            freq_reg  <= in_data[23:19];
            vol_reg   <= in_data[27:24];
            ticks_reg <= in_data[35:28];
            prio_reg  <= in_data[43:36];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TRACKS; i++)
            begin
                busy_reg[i]  <= 1'b0;
                clm_reg[i]   <= 1'b0;
                snd_reg[i]   <= '0;
                ptr_reg[i]   <= '0;
                dly_reg[i]   <= '0;
                rank_reg[i]  <= '0;
                start_reg[i] <= '0;
            end
            ti_reg <= '0;
            pv_reg <= 1'b0;
            bv_reg <= 1'b0;
            ch_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.kill)
            begin
                for (int i = 0; i < TRACKS; i++)
                begin
                    if (busy_reg[i] && snd_reg[i] == id_idx)
                    begin
                        busy_reg[i] <= 1'b0;
                    end
                end
            end
            if (cmd.kill_rep)
            begin
                for (int i = 0; i < TRACKS; i++)
                begin
                    if (busy_reg[i] && rank_reg[i] < 0)
                    begin
                        busy_reg[i] <= 1'b0;
                    end
                end
            end
            if (cmd.wr_sound)
            begin
                for (int i = 0; i < TRACKS; i++)
                begin
                    if (snd_reg[i] == id_idx)
                    begin
                        rank_reg[i]  <= prio_reg;
                        start_reg[i] <= PW'(addr_reg);
                    end
                end
            end

            if (cmd.scan_rst || cmd.ch_start)
            begin
                ti_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                ti_reg <= ti_reg + TW'(1);
            end

            if (cmd.clr_claim)
            begin
                for (int i = 0; i < TRACKS; i++)
                begin
                    clm_reg[i] <= 1'b0;
                end
            end

            if (cmd.add_cap)
            begin
                nstart_reg <= PW'(snd_rd[15:8]);
                nrank_reg  <= snd_rd[7:0];
                pv_reg     <= 1'b0;
            end
            if (cmd.add_eval)
            begin
                if (!busy_reg[ti_reg])
                begin
                    pick_reg <= ti_reg;
                end
                else if (rank_reg[ti_reg] > 0 && (!pv_reg || prank_reg > rank_reg[ti_reg]))
                begin
                    pick_reg  <= ti_reg;
                    pv_reg    <= 1'b1;
                    prank_reg <= rank_reg[ti_reg];
                end
            end
            if (cmd.add_commit)
            begin
                busy_reg[pick_reg]  <= 1'b1;
                snd_reg[pick_reg]   <= id_idx;
                ptr_reg[pick_reg]   <= nstart_reg;
                dly_reg[pick_reg]   <= srd_ticks;
                rank_reg[pick_reg]  <= nrank_reg;
                start_reg[pick_reg] <= nstart_reg;
            end

            if (cmd.tick_chk && busy_reg[ti_reg])
            begin
                if (dly_reg[ti_reg] != 8'd0)
                begin
                    dly_reg[ti_reg] <= dly_reg[ti_reg] - 8'd1;
                end
                else
                begin
                    ptr_reg[ti_reg] <= ptr_reg[ti_reg] + PW'(1);
                end
            end
            if (cmd.tick_kind)
            begin
                if (srd_kind == KIND_STOP)
                begin
                    busy_reg[ti_reg] <= 1'b0;
                    dly_reg[ti_reg]  <= dly_reg[ti_reg] - 8'd1;
                end
                else if (srd_kind == KIND_LOOP)
                begin
                    ptr_reg[ti_reg] <= start_reg[ti_reg];
                end
                else
                begin
                    dly_reg[ti_reg] <= srd_ticks - 8'd1;
                end
            end
            if (cmd.tick_loop_fin)
            begin
                dly_reg[ti_reg] <= srd_ticks - 8'd1;
            end

            if (cmd.ch_zero)
            begin
                ch_reg <= '0;
            end
            else if (cmd.ch_next)
            begin
                ch_reg <= ch_reg + CHW'(1);
            end
            if (cmd.ch_start)
            begin
                bv_reg <= 1'b0;
            end
            if (cmd.ch_ev)
            begin
                if (!bv_reg || bvol_reg < srd_vol ||
                    (bvol_reg == srd_vol && brank_reg < rank_reg[ti_reg]))
                begin
                    bv_reg    <= 1'b1;
                    best_reg  <= ti_reg;
                    bvol_reg  <= srd_vol;
                    bctrl_reg <= srd_ctrl;
                    bfreq_reg <= srd_freq;
                    brank_reg <= rank_reg[ti_reg];
                end
            end
            if (cmd.ch_out)
            begin
                ov_reg     <= 1'b1;
                o_chan_reg <= ch_reg[0];
                o_ctrl_reg <= bv_reg ? bctrl_reg : 4'd0;
                o_freq_reg <= bv_reg ? bfreq_reg : 5'd0;
                o_vol_reg  <= bv_reg ? bvol_reg : 4'd0;
                o_last_reg <= (ch_reg == CHW'(CHANNELS - 1));
                if (bv_reg)
                begin
                    clm_reg[best_reg] <= 1'b1;
                end
            end
            else if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign stat.action      = act_reg;
    assign stat.cur_busy    = busy_reg[ti_reg];
    assign stat.cur_claimed = clm_reg[ti_reg];
    assign stat.delay_zero  = (dly_reg[ti_reg] == 8'd0);
    assign stat.kind_loop   = (srd_kind == KIND_LOOP);
    assign stat.last_track  = (ti_reg == TW'(TRACKS - 1));
    assign stat.add_go      = pv_reg && (prank_reg < nrank_reg);
    assign stat.last_chan   = (ch_reg == CHW'(CHANNELS - 1));
    assign stat.out_taken   = ov_reg && out_ready;

    assign out_valid = ov_reg;
    assign out_data  = {2'b00, o_vol_reg, o_freq_reg, o_ctrl_reg, o_chan_reg};
    assign out_last  = o_last_reg;

endmodule

FILE: hdl/priority_sound_effect_sequencer_top.sv
// Top level of the priority sound-effect sequencer: controller plus datapath.
//
// The sequencer holds a step memory and a sound table, both filled by input items,
// and plays up to TRACKS sounds at once; a tick advances every busy track and emits
// CHANNELS result items, each taken from the loudest track not yet claimed, with
// the higher priority winning a tie, or zeros when no track is left. Items are
// handled one at a time: the input is ready only when the sequencer is idle.
// Load step, load sound, kill and kill repeating are done in the dispatch state. An add
// scans the tracks for a free or replaceable one. A tick first advances each busy track
// (the step memory's registered read port is shared by the marker and loop
// lookups), then for each channel scans the tracks for the loudest one and
// presents the result, which then waits for m_axis_tready. Step and sound memories
// hold no defined contents until written and need no clearing after reset.
module priority_sound_effect_sequencer_top
    import psfs_pkg::*;
#(
    parameter int TRACKS   = TRACKS_DEF,
    parameter int SOUNDS   = SOUNDS_DEF,
    parameter int STEPS    = STEPS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sound_id[4:0], step_address[12:5], step_kind[14:13], tone_control[18:15],
    // tone_frequency[23:19], tone_volume[27:24], step_ticks[35:28],
    // sound_priority[43:36], zero fill[47:44]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [ACTION_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // channel[0], out_control[4:1], out_frequency[9:5], out_volume[13:10],
    // zero fill[15:14]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // last
    output logic                  m_axis_tlast
);

    psfs_cmd_t  cmd;
    psfs_stat_t stat;
    logic       in_ready;

    assign s_axis_tready = in_ready;

    psfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && in_ready),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    psfs_dp #(
        .TRACKS   (TRACKS),
        .SOUNDS   (SOUNDS),
        .STEPS    (STEPS),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_user   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

FILE: hdl/psfs_checker.sv
// Port-level checker of the sequencer, bound to the top level.
module psfs_checker
    import psfs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [ACTION_W-1:0]   s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // No item is taken while a result item is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    // An accepted item never produces a result on the next cycle.
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result right after an accepted item");

    // Fill bits of the result are always zero.
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00)
        else $error("result fill bits not zero");

endmodule

bind priority_sound_effect_sequencer_top psfs_checker u_psfs_checker (.*);

FILE: test/tb.sv
// Self-checking testbench for the priority sound-effect sequencer top level.
`timescale 1ns / 100ps

module tb;
    import psfs_pkg::*;

    // Step kinds that the package does not name.
    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_ODD    = 2'd3;
    // Action codes that the sequencer ignores.
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS = 1290;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] ctrl;
        logic [4:0] freq;
        logic [3:0] vol;
        logic [7:0] ticks;
    } step_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [IN_DATA_W-1:0] data;
    } cmd_item_t;

    typedef struct packed {
        logic       channel;
        logic [3:0] ctrl;
        logic [4:0] freq;
        logic [3:0] vol;
        logic       last;
    } voice_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [ACTION_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    priority_sound_effect_sequencer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the sequencer's memories and track state.
    step_t              step_mem [256];
    logic [7:0]         snd_first [32];
    logic signed [7:0]  snd_prio [32];
    logic               trk_busy [4];
    logic [4:0]         trk_snd [4];
    logic [7:0]         trk_ptr [4];
    logic [7:0]         trk_wait [4];
    logic               trk_taken [4];

    cmd_item_t pending_items[$];
    voice_t    expected_voices[$];

    int  errors = 0;
    int  voices_seen = 0;
    int  ticks_sent = 0;
    int  adds_sent = 0;
    int  cycles = 0;
    bit  stim_done = 0;

    // Clock and the single reset at the start of the run.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [IN_DATA_W-1:0] pack_fields(
        input logic [4:0] sid, input logic [7:0] addr, input logic [1:0] kind,
        input logic [3:0] ctrl, input logic [4:0] freq, input logic [3:0] vol,
        input logic [7:0] ticks, input logic [7:0] prio);
        return {4'd0, prio, ticks, vol, freq, ctrl, kind, addr, sid};
    endfunction

    // Advances the shadow model by one item and queues the channel items it causes.
    task automatic predict_item(input cmd_item_t it);
        logic [4:0]        sid;
        logic [7:0]        addr;
        int                pick;
        bit                pick_free;
        int                best;
        logic signed [7:0] r;
        step_t             s;
        voice_t            v;
        sid  = it.data[4:0];
        addr = it.data[12:5];
        case (it.action)
            ACT_LOAD_STEP:
                step_mem[addr] = {it.data[14:13], it.data[18:15], it.data[23:19],
                                  it.data[27:24], it.data[35:28]};
            ACT_LOAD_SOUND:
            begin
                snd_first[sid] = addr;
                snd_prio[sid]  = it.data[43:36];
            end
            ACT_ADD:
            begin
                pick = -1;
                pick_free = 0;
                for (int i = 0; i < 4; i++)
                begin
                    if (!trk_busy[i])
                    begin
                        pick = i;
                        pick_free = 1;
                        break;
                    end
                    r = snd_prio[trk_snd[i]];
                    if (r > 0 && (pick < 0 || snd_prio[trk_snd[pick]] > r))
                        pick = i;
                end
                if (pick >= 0 && (pick_free || snd_prio[trk_snd[pick]] < snd_prio[sid]))
                begin
                    trk_busy[pick] = 1'b1;
                    trk_snd[pick]  = sid;
                    trk_ptr[pick]  = snd_first[sid];
                    trk_wait[pick] = step_mem[snd_first[sid]].ticks;
                end
            end
            ACT_KILL:
                for (int i = 0; i < 4; i++)
                    if (trk_busy[i] && trk_snd[i] == sid)
                        trk_busy[i] = 1'b0;
            ACT_KILL_REP:
                for (int i = 0; i < 4; i++)
                    if (trk_busy[i] && snd_prio[trk_snd[i]] < 0)
                        trk_busy[i] = 1'b0;
            ACT_TICK:
            begin
                // Advance every busy track; a stop marker frees it, a loop
                // marker jumps back to the sound's first step.
                for (int i = 0; i < 4; i++)
                begin
                    trk_taken[i] = 1'b0;
                    if (!trk_busy[i])
                        continue;
                    if (trk_wait[i] == 8'd0)
                    begin
                        trk_ptr[i] = trk_ptr[i] + 8'd1;
                        if (step_mem[trk_ptr[i]].kind == KIND_STOP)
                            trk_busy[i] = 1'b0;
                        else
                        begin
                            if (step_mem[trk_ptr[i]].kind == KIND_LOOP)
                                trk_ptr[i] = snd_first[trk_snd[i]];
                            trk_wait[i] = step_mem[trk_ptr[i]].ticks;
                        end
                    end
                    trk_wait[i] = trk_wait[i] - 8'd1;
                end
                // Each channel takes the loudest unclaimed track, priority on a tie.
                for (int c = 0; c < 2; c++)
                begin
                    best = -1;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (!trk_busy[i] || trk_taken[i])
                            continue;
                        if (best < 0)
                            best = i;
                        else if (step_mem[trk_ptr[best]].vol < step_mem[trk_ptr[i]].vol ||
                                 (step_mem[trk_ptr[best]].vol == step_mem[trk_ptr[i]].vol &&
                                  snd_prio[trk_snd[best]] < snd_prio[trk_snd[i]]))
                            best = i;
                    end
                    v = '0;
                    v.channel = c[0];
                    v.last = (c == 1);
                    if (best >= 0)
                    begin
                        s = step_mem[trk_ptr[best]];
                        trk_taken[best] = 1'b1;
                        v.ctrl = s.ctrl;
                        v.freq = s.freq;
                        v.vol  = s.vol;
                    end
                    expected_voices.push_back(v);
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [IN_DATA_W-1:0] d);
        cmd_item_t it;
        it.action = act;
        it.data = d;
        if (act == ACT_TICK)
            ticks_sent++;
        if (act == ACT_ADD)
            adds_sent++;
        predict_item(it);
        pending_items.push_back(it);
    endtask

    task automatic queue_step(input logic [7:0] addr, input logic [1:0] kind,
                              input logic [7:0] ticks);
        queue_item(ACT_LOAD_STEP, pack_fields($urandom, addr, kind, $urandom, $urandom,
                                              $urandom, ticks, $urandom));
    endtask

    task automatic queue_sound(input logic [4:0] sid, input logic [7:0] addr,
                               input logic [7:0] prio);
        queue_item(ACT_LOAD_SOUND, pack_fields(sid, addr, $urandom, $urandom, $urandom,
                                               $urandom, $urandom, prio));
    endtask

    task automatic queue_simple(input logic [ACTION_W-1:0] act, input logic [4:0] sid);
        queue_item(act, pack_fields(sid, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom));
    endtask

    function automatic logic [1:0] pick_kind();
        int w;
        w = $urandom_range(0, 19);
        if (w < 12)
            return KIND_NORMAL;
        else if (w < 15)
            return KIND_STOP;
        else if (w < 18)
            return KIND_LOOP;
        return KIND_ODD;
    endfunction

    function automatic logic [7:0] pick_ticks();
        int w;
        w = $urandom_range(0, 49);
        if (w == 0)
            return 8'd0;
        else if (w < 3)
            return $urandom_range(1, 255);
        return $urandom_range(1, 4);
    endfunction

    // Stimulus: every memory entry is written first, so that no read of an
    // unwritten entry can occur; then directed corner items, then random ones.
    initial
    begin
        int w;
        for (int i = 0; i < 4; i++)
        begin
            trk_busy[i] = 0;
            trk_snd[i] = 0;
            trk_ptr[i] = 0;
            trk_wait[i] = 0;
            trk_taken[i] = 0;
        end
        for (int a = 0; a < 256; a++)
            queue_step(a[7:0], pick_kind(), pick_ticks());
        for (int k = 0; k < 32; k++)
            queue_sound(k[4:0], $urandom, $urandom_range(1, 100));

        // Stop marker as the first step, a sound near the top of memory that
        // wraps to address zero, and priority extremes including locked ones.
        queue_step(8'd10, KIND_STOP, 8'd2);
        queue_step(8'd255, KIND_NORMAL, 8'd1);
        queue_step(8'd0, KIND_LOOP, 8'd3);
        queue_step(8'd20, KIND_NORMAL, 8'd0);
        queue_sound(5'd0, 8'd10, 8'sd127);
        queue_sound(5'd31, 8'd255, 8'h80);
        queue_sound(5'd1, 8'd20, 8'd0);
        queue_sound(5'd2, 8'd255, 8'd1);
        queue_simple(ACT_ADD, 5'd0);
        queue_simple(ACT_ADD, 5'd31);
        queue_simple(ACT_ADD, 5'd1);
        queue_simple(ACT_ADD, 5'd2);
        queue_simple(ACT_ADD, 5'd2);
        queue_simple(ACT_ADD, 5'd0);
        queue_simple(ACT_TICK, 5'd0);
        queue_simple(ACT_TICK, 5'd0);
        queue_simple(ACT_TICK, 5'd0);
        queue_simple(ACT_SPARE_A, 5'd0);
        queue_simple(ACT_SPARE_B, 5'd0);
        queue_simple(ACT_KILL_REP, 5'd0);
        queue_simple(ACT_TICK, 5'd0);
        queue_simple(ACT_KILL, 5'd1);
        queue_simple(ACT_TICK, 5'd0);

        // Random part: mostly ticks and adds over the loaded sounds.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 45)
                queue_simple(ACT_TICK, $urandom);
            else if (w < 65)
                queue_simple(ACT_ADD, $urandom);
            else if (w < 80)
                queue_step($urandom, pick_kind(), pick_ticks());
            else if (w < 88)
                queue_sound($urandom, $urandom, $urandom);
            else if (w < 93)
                queue_simple(ACT_KILL, $urandom);
            else if (w < 97)
                queue_simple(ACT_KILL_REP, $urandom);
            else
                queue_simple($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, $urandom);
        end
        stim_done = 1;
    end

    // Driver: presents the head of the pending queue, idling in random bursts
    // until the final stretch of the run.
    int  send_gap = 0;
    bit  nxt_valid;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            nxt_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                void'(pending_items.pop_front());
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (stim_done && pending_items.size() > 0)
                begin
                    if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 12) - 1;
                    else
                        nxt_valid = 1'b1;
                end
            end
            s_axis_tvalid <= nxt_valid;
            if (nxt_valid)
            begin
                s_axis_tdata <= pending_items[0].data;
                s_axis_tuser <= pending_items[0].action;
            end
        end
    end

    // Monitor: stalls the result stream in bursts and checks each accepted item.
    int  stall_left = 0;
    bit  nxt_ready;
    voice_t got, want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[9:5],
                       m_axis_tdata[13:10], m_axis_tlast};
                voices_seen++;
                if (expected_voices.size() == 0)
                begin
                    $display("%0t: channel item with nothing expected: %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_voices.pop_front();
                    if (got.channel !== want.channel)
                    begin
                        $display("%0t: channel expected %0d actual %0d",
                                 $time, want.channel, got.channel);
                        errors++;
                    end
                    if (got.ctrl !== want.ctrl)
                    begin
                        $display("%0t: control expected %0d actual %0d",
                                 $time, want.ctrl, got.ctrl);
                        errors++;
                    end
                    if (got.freq !== want.freq)
                    begin
                        $display("%0t: frequency expected %0d actual %0d",
                                 $time, want.freq, got.freq);
                        errors++;
                    end
                    if (got.vol !== want.vol)
                    begin
                        $display("%0t: volume expected %0d actual %0d",
                                 $time, want.vol, got.vol);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, got.last);
                        errors++;
                    end
                end
            end
            nxt_ready = 1'b1;
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                nxt_ready = 1'b0;
            end
            m_axis_tready <= nxt_ready;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d channel items still expected",
                     cycles, expected_voices.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // End of run: all items taken, all channel items seen, then a short drain.
    initial
    begin
        wait (stim_done);
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_voices.size() == 0);
        repeat (200) @(posedge clk);
        $display("Ran %0d ticks and %0d adds, checking %0d channel items.",
                 ticks_sent, adds_sent, voices_seen);
        if (errors == 0 && expected_voices.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hdl/psfs_pkg.sv
hdl/psfs_ram.sv
hdl/psfs_ctrl.sv
hdl/psfs_dp.sv
hdl/priority_sound_effect_sequencer_top.sv
hdl/psfs_checker.sv
test/tb.sv
